/* design/paids_pkg.sv */
// shared types and constants of the positional array block
package paids_pkg;

    localparam int DEPTH = 64;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = 7;
    localparam int VW = 32;

    localparam int IN_W = 48;
    localparam int OUT_W = 16;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_SEARCH = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_SEARCH,
        S_DONE
    } state_t;

endpackage

/* design/positional_array_insert_delete_search.sv */
// top level: ordered array with insert, delete and linear search over one ram
//
// requests arrive on the s_ channel, one item each: type, 1-based position and
// value. every request gives exactly one result item on the m_ channel with a
// status, the found position and the entry count after the request.
// the entries live in a 64 x 32 ram with a registered read.
// insert at position p with count c moves c-p+1 entries, one per cycle, then
// finishes the last move and writes the new value. delete moves c-p entries.
// search reads one entry a cycle and stops at the first match or the count.
// rejected requests go straight to the result. the ram port does one read
// and one write per cycle; the next item can be taken the cycle after the
// result loads. one request is worked on at a time; a new one is taken while
// the previous result still waits in the output register.
// when the receiver stalls, the result holds in the output register and the
// next request stops before loading its own result.
// reset clears the entry count and the handshake state; ram contents stay
// undefined, and only entries below the count are ever read.
module positional_array_insert_delete_search
    import paids_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // req_type[1:0], position[8:2], item_value[40:9]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status[1:0], found_position[8:2], entry_count[15:9]
);

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    k_reg, k_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [VW-1:0]    value_reg, value_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    pend_addr_reg, pend_addr_next;
    status_t          res_status_reg, res_status_next;
    logic [CW-1:0]    res_found_reg, res_found_next;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [VW-1:0]    ram_wdata, ram_rdata;

    logic [1:0]       in_req;
    logic [CW-1:0]    in_pos;
    logic [VW-1:0]    in_value;
    logic [CW-1:0]    k_m1, pos_m1;

    assign in_req   = s_tdata[1:0];
    assign in_pos   = s_tdata[8:2];
    assign in_value = s_tdata[40:9];
    assign k_m1     = k_reg - CW'(1);
    assign pos_m1   = pos_reg - CW'(1);

    paids_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        pos_reg        <= pos_next;
        value_reg      <= value_next;
        pend_addr_reg  <= pend_addr_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        out_data_reg   <= out_data_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        pos_next        = pos_reg;
        value_next      = value_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = pend_addr_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = k_reg[AW-1:0];
        s_tready        = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    pos_next        = in_pos;
                    value_next      = in_value;
                    res_found_next  = '0;
                    res_status_next = ST_BADPOS;
                    state_next      = S_DONE;
                    case (in_req)
                        REQ_INSERT:
                        begin
                            if (count_reg >= CW'(DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (in_pos != '0 && in_pos <= count_reg + CW'(1))
                            begin
                                k_next     = count_reg;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (in_pos != '0 && in_pos <= count_reg)
                            begin
                                k_next     = in_pos;
                                state_next = S_SHIFT_DN;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            k_next     = '0;
                            state_next = S_SEARCH;
                        end
                        default:
                        begin
                            res_status_next = ST_BADPOS;
                        end
                    endcase
                end
            end

            S_SHIFT_UP:
            begin
                // read entry k-1 now, write it into entry k next cycle
                ram_we = pend_reg;
                if (k_reg >= pos_reg)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = k_m1[AW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = k_reg[AW-1:0];
                    k_next         = k_m1;
                end
                else if (!pend_reg)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = pos_m1[AW-1:0];
                    ram_wdata       = value_reg;
                    count_next      = count_reg + CW'(1);
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                end
            end

            S_SHIFT_DN:
            begin
                ram_we = pend_reg;
                if (k_reg < count_reg)
                begin
                    ram_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = k_m1[AW-1:0];
                    k_next         = k_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    count_next      = count_reg - CW'(1);
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                end
            end

            S_SEARCH:
            begin
                if (pend_reg && ram_rdata == value_reg)
                begin
                    res_status_next = ST_OK;
                    res_found_next  = CW'(pend_addr_reg) + CW'(1);
                    state_next      = S_DONE;
                end
                else if (k_reg < count_reg)
                begin
                    ram_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = k_reg[AW-1:0];
                    k_next         = k_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    res_status_next = ST_NOTFOUND;
                    res_found_next  = '0;
                    state_next      = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {count_reg, res_found_reg, res_status_reg};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("ram read and write hit the same entry");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[8:2] != '0 |-> m_tdata[1:0] == ST_OK)
        else $error("found position without ok status");

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg != S_IDLE)
        else $error("accepted item left no work");

endmodule

/* design/paids_ram.sv */
// generic single-write, single-read ram with registered read data
module paids_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* test/positional_array_insert_delete_search_test.sv */
// self-checking testbench for the positional array insert, delete and search block
module positional_array_insert_delete_search_test
    import paids_pkg::*;
();

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [VW-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VW-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam int RANDOM_ITEMS = 600;

    typedef struct packed {
        status_t         status;
        logic [CW-1:0]   found;
        logic [CW-1:0]   count;
    } array_result_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;   // req_type[1:0], position[8:2], item_value[40:9]
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;   // status[1:0], found_position[8:2], entry_count[15:9]

    // predictor state
    logic [VW-1:0] array_copy[DEPTH];
    int            array_used;

    // stimulus side: requests waiting to go out and the contents they should build
    logic [IN_W-1:0] pending_requests[$];
    logic [VW-1:0]   planned_values[$];
    array_result_t   expected_results[$];
    array_result_t   oldest;

    bit req_accepted;
    int requests_taken;
    int total_requests;
    int mismatch_count;
    int cycle_count;

    positional_array_insert_delete_search dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [IN_W-1:0] pack_request(input logic [1:0] code,
                                                     input logic [CW-1:0] pos,
                                                     input logic [VW-1:0] val);
        return {{(IN_W - 41){1'b0}}, val, pos, code};
    endfunction

    // works out the result of one request and updates the array copy
    function automatic array_result_t apply_request(input logic [IN_W-1:0] word);
        logic [1:0]    code;
        int            pos;
        logic [VW-1:0] val;
        array_result_t r;
        code = word[1:0];
        pos = word[8:2];
        val = word[40:9];
        r.status = ST_BADPOS;
        r.found = '0;
        case (code)
            REQ_INSERT:
            begin
                if (array_used >= DEPTH)
                    r.status = ST_FULL;
                else if (pos >= 1 && pos <= array_used + 1)
                begin
                    for (int k = array_used; k >= pos; k--)
                        array_copy[k] = array_copy[k - 1];
                    array_copy[pos - 1] = val;
                    array_used++;
                    r.status = ST_OK;
                end
            end
            REQ_DELETE:
            begin
                if (pos >= 1 && pos <= array_used)
                begin
                    for (int k = pos; k < array_used; k++)
                        array_copy[k - 1] = array_copy[k];
                    array_used--;
                    r.status = ST_OK;
                end
            end
            REQ_SEARCH:
            begin
                r.status = ST_NOTFOUND;
                // walk downward so the lowest match wins
                for (int k = array_used - 1; k >= 0; k--)
                begin
                    if (array_copy[k] == val)
                    begin
                        r.status = ST_OK;
                        r.found = CW'(k + 1);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count = CW'(array_used);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    // queues one request and tracks what the array will hold once it is done
    task automatic plan_request(input logic [1:0] code, input logic [CW-1:0] pos,
                                input logic [VW-1:0] val);
        pending_requests.push_back(pack_request(code, pos, val));
        if (code == REQ_INSERT && planned_values.size() < DEPTH && pos >= 1
            && pos <= planned_values.size() + 1)
            planned_values.insert(pos - 1, val);
        else if (code == REQ_DELETE && pos >= 1 && pos <= planned_values.size())
            planned_values.delete(pos - 1);
    endtask

    function automatic logic [VW-1:0] pick_value(input int reuse_pct);
        int roll;
        roll = $urandom_range(99);
        if (planned_values.size() > 0 && roll < reuse_pct)
            return planned_values[$urandom_range(planned_values.size() - 1)];
        if (roll < reuse_pct + 15)
        begin
            case ($urandom_range(3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        return $urandom();
    endfunction

    function automatic bit take_break();
        // no idling in one long stretch of the run
        if (cycle_count >= 4000 && cycle_count < 10000)
            return 1'b0;
        return $urandom_range(99) < 20;
    endfunction

    // driver: both handshake sides change on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || req_accepted)
            begin
                if (pending_requests.size() > 0 && !take_break())
                begin
                    s_tdata <= pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= !take_break();
        end
    end

    // monitor: predicts on accepted requests and checks accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            req_accepted <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing outstanding, data", m_tdata, 0);
                else
                begin
                    oldest = expected_results.pop_front();
                    if (m_tdata[1:0] !== oldest.status)
                        report_mismatch("status", m_tdata[1:0], oldest.status);
                    if (m_tdata[8:2] !== oldest.found)
                        report_mismatch("found_position", m_tdata[8:2], oldest.found);
                    if (m_tdata[15:9] !== oldest.count)
                        report_mismatch("entry_count", m_tdata[15:9], oldest.count);
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(apply_request(s_tdata));
                requests_taken++;
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("positional_array_insert_delete_search: mismatch");
        $finish;
    end

    initial
    begin
        int            roll;
        bit            grow;
        logic [CW-1:0] pos;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        req_accepted = 1'b0;
        array_used = 0;
        requests_taken = 0;
        mismatch_count = 0;
        cycle_count = 0;

        // directed: empty array, bad positions, unused code, extremes, first match
        plan_request(REQ_DELETE, 7'd1, '0);
        plan_request(REQ_SEARCH, '0, '0);
        plan_request(REQ_UNUSED, 7'd1, 32'h1234_5678);
        plan_request(REQ_INSERT, 7'd0, 32'd5);
        plan_request(REQ_INSERT, 7'd2, 32'd5);
        plan_request(REQ_INSERT, 7'd1, VAL_MAX);
        plan_request(REQ_INSERT, 7'd2, VAL_MIN);
        plan_request(REQ_INSERT, 7'd1, '0);
        plan_request(REQ_INSERT, 7'h7f, '1);
        plan_request(REQ_INSERT, 7'd2, '1);
        plan_request(REQ_SEARCH, 7'h7f, VAL_MIN);
        plan_request(REQ_SEARCH, '0, '1);
        plan_request(REQ_SEARCH, '0, 32'd12345);
        plan_request(REQ_INSERT, 7'd5, '0);
        plan_request(REQ_SEARCH, '0, '0);
        plan_request(REQ_DELETE, 7'd6, '0);
        plan_request(REQ_DELETE, 7'd5, '0);
        plan_request(REQ_DELETE, 7'd1, '0);
        plan_request(REQ_DELETE, 7'd0, '0);
        plan_request(REQ_DELETE, 7'h7f, '1);
        plan_request(REQ_UNUSED, 7'h7f, '1);
        plan_request(REQ_SEARCH, '0, VAL_MAX);

        // random: alternate filling to full and draining to empty
        grow = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (grow && planned_values.size() == DEPTH && $urandom_range(3) == 0)
                grow = 1'b0;
            if (!grow && planned_values.size() == 0 && $urandom_range(3) == 0)
                grow = 1'b1;
            roll = $urandom_range(99);
            if (roll < 5)
                plan_request(2'($urandom_range(3)), CW'($urandom_range(127)), $urandom());
            else if (roll < (grow ? 70 : 25))
            begin
                if ($urandom_range(99) < 85)
                    pos = CW'($urandom_range(planned_values.size() + 1, 1));
                else
                    pos = CW'($urandom_range(127));
                plan_request(REQ_INSERT, pos, pick_value(25));
            end
            else if (roll < 80)
            begin
                if (planned_values.size() > 0 && $urandom_range(99) < 85)
                    pos = CW'($urandom_range(planned_values.size(), 1));
                else
                    pos = CW'($urandom_range(127));
                plan_request(REQ_DELETE, pos, $urandom());
            end
            else
                plan_request(REQ_SEARCH, CW'($urandom_range(127)), pick_value(60));
        end
        total_requests = pending_requests.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (requests_taken < total_requests)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (mismatch_count == 0)
            $display("positional_array_insert_delete_search: match");
        else
            $display("positional_array_insert_delete_search: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
design/paids_pkg.sv
design/paids_ram.sv
design/positional_array_insert_delete_search.sv
test/positional_array_insert_delete_search_test.sv
